[hdl/sitoa_pkg.sv]
package sitoa_pkg;

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } result_t;

    // Number of decimal digits needed for a magnitude of up to 2^(w-1).
    function automatic int dec_digits(input int w);
        return (((w - 1) * 1233) >> 12) + 1;
    endfunction

endpackage

[hdl/sitoa_fifo.sv]
module sitoa_fifo
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[hdl/sitoa_front.sv]
module sitoa_front
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                   push,
    input  logic [VALUE_WIDTH-1:0] value,
    output logic                   full,
    input  logic                   item_full,
    output logic                   item_wr,
    output logic [VALUE_WIDTH:0]   item_data
);

    logic                   neg;
    logic [VALUE_WIDTH-1:0] mag;

    // The magnitude of the most negative value, 2^(W-1), fits the unsigned word.
    assign neg       = value[VALUE_WIDTH-1];
    assign mag       = neg ? (~value + 1'b1) : value;
    assign full      = item_full;
    assign item_wr   = push && !item_full;
    assign item_data = {neg, mag};

endmodule

[hdl/sitoa_back.sv]
module sitoa_back
    import sitoa_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_empty,
    input  logic [VALUE_WIDTH:0] item_data,
    output logic                 item_pop,
    input  logic                 res_full,
    output logic                 res_push,
    output result_t              res
);

    localparam int NDIG  = dec_digits(VALUE_WIDTH);
    localparam int BCD_W = 4 * NDIG;
    localparam int BIT_W = $clog2(VALUE_WIDTH + 1);
    localparam int DIG_W = $clog2(NDIG + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SIGN = 3'd1;
    localparam logic [2:0] ST_CONV = 3'd2;
    localparam logic [2:0] ST_SKIP = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic [BIT_W-1:0]       bit_cnt_reg, bit_cnt_next;
    logic [DIG_W-1:0]       dig_left_reg, dig_left_next;
    logic [BCD_W-1:0]       bcd_adj;
    logic [3:0]             top_digit;

    // Add three to every digit of five or more before the next left shift.
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            bcd_adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ?
                                bcd_reg[4*i +: 4] + 4'd3 : bcd_reg[4*i +: 4];
        end
    end

    assign top_digit = bcd_reg[BCD_W-1 -: 4];

    always_comb
    begin
        state_next    = state_reg;
        mag_next      = mag_reg;
        bcd_next      = bcd_reg;
        bit_cnt_next  = bit_cnt_reg;
        dig_left_next = dig_left_reg;
        item_pop      = 1'b0;
        res_push      = 1'b0;
        res.character = CHAR_ZERO + {4'b0000, top_digit};
        res.last      = (dig_left_reg == DIG_W'(1));
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!item_empty)
                begin
                    item_pop     = 1'b1;
                    mag_next     = item_data[VALUE_WIDTH-1:0];
                    bcd_next     = '0;
                    bit_cnt_next = BIT_W'(VALUE_WIDTH);
                    state_next   = item_data[VALUE_WIDTH] ? ST_SIGN : ST_CONV;
                end
            end
            ST_SIGN:
            begin
                res.character = CHAR_MINUS;
                res.last      = 1'b0;
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next     = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_WIDTH-1]};
                mag_next     = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == BIT_W'(1))
                begin
                    dig_left_next = DIG_W'(NDIG);
                    state_next    = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (top_digit == 4'd0 && dig_left_reg != DIG_W'(1))
                begin
                    bcd_next      = {bcd_reg[BCD_W-5:0], 4'd0};
                    dig_left_next = dig_left_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!res_full)
                begin
                    res_push = 1'b1;
                    if (dig_left_reg == DIG_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        bcd_next      = {bcd_reg[BCD_W-5:0], 4'd0};
                        dig_left_next = dig_left_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        bcd_reg      <= bcd_next;
        bit_cnt_reg  <= bit_cnt_next;
        dig_left_reg <= dig_left_next;
    end

endmodule

[hdl/signed_int_to_decimal_ascii_top.sv]
// A negative value first emits its minus sign. The binary-to-BCD converter (shift-and-add-three)
// then shifts one bit a cycle, leading zero digits are skipped, and the digits are emitted one
// character per cycle while the result queue is not full. The input queue can accept new values,
// until it is full, while the converter is still working on an earlier one.
// Reset clears both queues and the converter state; no value survives reset.
module signed_int_to_decimal_ascii_top
    import sitoa_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [VALUE_WIDTH-1:0] value,
    output logic                          empty,
    input  logic                          pop,
    output logic [7:0]                    character,
    output logic                          last
);

    localparam int RES_W = $bits(result_t);

    logic                 item_full;
    logic                 item_empty;
    logic                 item_wr;
    logic                 item_pop;
    logic [VALUE_WIDTH:0] item_wr_data;
    logic [VALUE_WIDTH:0] item_rd_data;
    logic                 res_full;
    logic                 res_push;
    result_t              res_in;
    result_t              res_out;
    logic [RES_W-1:0]     res_rd_data;

    sitoa_front #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_front (
        .push     (push),
        .value    (value),
        .full     (full),
        .item_full(item_full),
        .item_wr  (item_wr),
        .item_data(item_wr_data)
    );

    sitoa_fifo #(
        .WIDTH(VALUE_WIDTH + 1),
        .DEPTH(2)
    ) u_item_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (item_wr),
        .wr_data(item_wr_data),
        .full   (item_full),
        .rd_en  (item_pop),
        .rd_data(item_rd_data),
        .empty  (item_empty)
    );

    sitoa_back #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_empty(item_empty),
        .item_data (item_rd_data),
        .item_pop  (item_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    sitoa_fifo #(
        .WIDTH(RES_W),
        .DEPTH(2)
    ) u_res_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (res_push),
        .wr_data(res_in),
        .full   (res_full),
        .rd_en  (pop),
        .rd_data(res_rd_data),
        .empty  (empty)
    );

    assign res_out   = result_t'(res_rd_data);
    assign character = res_out.character;
    assign last      = res_out.last;

endmodule

[verif/signed_int_to_decimal_ascii_top_tb.sv]
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_top_tb;
    import sitoa_pkg::*;

    localparam int WIDTH = 32;
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 60;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    push = 1'b0;
    logic signed [WIDTH-1:0] value = '0;
    logic                    pop = 1'b0;
    logic                    full;
    logic                    empty;
    logic [7:0]              character;
    logic                    last;

    result_t pending_chars[$];
    int      mismatch_count = 0;
    int      quiet_cycles = 0;
    int      receiver_hold_cycles = 0;
    bit      sender_idle_en = 1'b1;
    bit      receiver_idle_en = 1'b1;

    signed_int_to_decimal_ascii_top #(.VALUE_WIDTH(WIDTH)) dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .value(value),
        .empty(empty),
        .pop(pop),
        .character(character),
        .last(last)
    );

    always #6 clk = ~clk;

    // Expected text: optional minus sign, then the digits of the magnitude, most
    // significant first. The magnitude carries one extra bit for the most negative value.
    function automatic void predict_decimal_text(input logic signed [WIDTH-1:0] v);
        logic [WIDTH:0] magnitude;
        logic [7:0]     digit_chars[$];
        result_t        r;
        bit             negative;
        negative = v[WIDTH-1];
        magnitude = negative ? ({(WIDTH + 1){1'b0}} - {v[WIDTH-1], v}) : {1'b0, v};
        do
        begin
            digit_chars.push_front(CHAR_ZERO + 8'(magnitude % 10));
            magnitude = magnitude / 10;
        end
        while (magnitude != 0);
        if (negative)
        begin
            r.character = CHAR_MINUS;
            r.last = 1'b0;
            pending_chars.push_back(r);
        end
        foreach (digit_chars[i])
        begin
            r.character = digit_chars[i];
            r.last = (i == digit_chars.size() - 1);
            pending_chars.push_back(r);
        end
    endfunction

    function automatic logic signed [WIDTH-1:0] random_value();
        int unsigned          pick;
        int unsigned          k;
        int unsigned          bound;
        logic signed [WIDTH-1:0] v;
        pick = $urandom_range(0, 3);
        k = $urandom_range(0, 9);
        bound = 1;
        repeat (k) bound = bound * 10;
        case (pick)
            0: v = $urandom;
            1: v = (k == 9) ? $urandom : $urandom_range(0, bound * 10 - 1);
            2: v = bound + $urandom_range(0, 2) - 1;
            default:
            begin
                if ($urandom_range(0, 1))
                    v = 32'sh8000_0000 + $urandom_range(0, 3);
                else
                    v = 32'sh7fff_ffff - $urandom_range(0, 3);
            end
        endcase
        if (pick inside {1, 2} && $urandom_range(0, 1))
            v = -v;
        return v;
    endfunction

    task automatic send_value(input logic signed [WIDTH-1:0] v);
        while (sender_idle_en && $urandom_range(0, 99) < 31)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        value <= v;
        do
            @(posedge clk);
        while (full);
        predict_decimal_text(v);
    endtask

    task automatic wait_until_drained();
        push <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
    endtask

    // Result side: check every accepted character, then choose the next pop.
    initial
    begin
        result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                if (pending_chars.size() == 0)
                begin
                    $error("unexpected result: character %0d last %0d", character, last);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_chars.pop_front();
                    if (character !== want.character)
                    begin
                        $error("character: expected %0d, got %0d", want.character, character);
                        mismatch_count++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, last);
                        mismatch_count++;
                    end
                end
            end
            if (receiver_hold_cycles > 0)
            begin
                pop <= 1'b0;
                receiver_hold_cycles--;
            end
            else
            begin
                pop <= !(receiver_idle_en && $urandom_range(0, 99) < 31);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic test_directed();
        logic signed [WIDTH-1:0] corner_values[$];
        corner_values = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 32'sh7fff_ffff,
                          32'sh8000_0000, 32'sh8000_0001, 32'sh7fff_fffe, 1000000000,
                          999999999, -999999999, -1000000000, 1234567890, -1234567890,
                          32'sh5555_5555, 32'shaaaa_aaaa, 7};
        foreach (corner_values[i])
            send_value(corner_values[i]);
    endtask

    task automatic test_random(input int count);
        repeat (count) send_value(random_value());
    endtask

    task automatic test_no_idling();
        sender_idle_en = 1'b0;
        receiver_idle_en = 1'b0;
        repeat (30) send_value(random_value());
        sender_idle_en = 1'b1;
        receiver_idle_en = 1'b1;
    endtask

    task automatic test_receiver_backpressure();
        receiver_hold_cycles = 600;
        repeat (40) send_value(random_value());
    endtask

    task automatic test_sender_pause();
        repeat (10) send_value(random_value());
        wait_until_drained();
        repeat (10) send_value(random_value());
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(100);
        test_no_idling();
        test_receiver_backpressure();
        test_sender_pause();
        test_random(80);
        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[sim.f]
hdl/sitoa_pkg.sv
hdl/sitoa_fifo.sv
hdl/sitoa_front.sv
hdl/sitoa_back.sv
hdl/signed_int_to_decimal_ascii_top.sv
verif/signed_int_to_decimal_ascii_top_tb.sv
